// ===== hdl/drs_pkg.sv =====
// ----------------------------------------------------------------------------
// Disk request scheduler package
// Shared constants, codes, transaction types and sequencer states.
// ----------------------------------------------------------------------------
package drs_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_ARRIVE   = 1'b0;
  localparam logic OP_COMPLETE = 1'b1;

  localparam logic POLICY_FCFS = 1'b0;
  localparam logic POLICY_SSTF = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_DROPPED = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [15:0] new_request_id;
    logic [15:0] new_process_id;
    logic [31:0] new_block_address;
    logic [15:0] new_cylinder;
    logic [31:0] new_arrival_time;
    logic [15:0] head_cylinder;
  } drs_req_t;

  typedef struct packed {
    logic        status;
    logic        serving_valid;
    logic [15:0] serving_request_id;
    logic [15:0] serving_process_id;
    logic [31:0] serving_block_address;
    logic [15:0] serving_cylinder;
    logic [31:0] serving_arrival_time;
    logic [4:0]  pending_count;
  } drs_rsp_t;

  typedef struct packed {
    logic [15:0] req_tag;
    logic [15:0] proc_tag;
    logic [31:0] block_address;
    logic [15:0] cylinder;
    logic [31:0] arrival_time;
  } drs_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_FIN
  } drs_state_t;

endpackage

// ===== hdl/disk_request_scheduler.sv =====
// ----------------------------------------------------------------------------
// Disk request scheduler
// Keeps one request in service and a queue of pending requests, and picks
// the next one by arrival order or by shortest seek on each completion.
//
// The req channel carries one command per transaction: an arrival or a
// completion. The rsp channel returns exactly one transaction per command
// with the drop status, the request now in service and the queue length.
// The user must write the policy register through policy_we and policy_data
// only while no command is in progress; the block does not enforce this.
// An arrival, or a completion with an empty queue, goes from idle straight
// to the final state, which loads the response and raises rsp_valid. A
// completion with queued requests first scans the queue, where the single
// compare unit takes one queue entry per cycle, then moves the later
// entries down when the picked position is not the last one, and then
// loads the response in the final state. The next command can be taken in
// the cycle after the response is loaded.
// Only one command is in progress at a time; req_stall is high while busy.
// A response still held by rsp_stall keeps the next command in its final
// state until it is taken. Reset empties the queue, clears the request in service and
// selects first come first served; no clearing pass is needed.
// ----------------------------------------------------------------------------
module disk_request_scheduler
  import drs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  drs_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output drs_rsp_t rsp,
  input  logic     policy_we,
  input  logic     policy_data
);

  drs_state_t        state;
  drs_state_t        state_next;
  logic              policy_mode;
  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  total_m1;
  logic [CNT_W-1:0]  ptr;
  logic [CNT_W-1:0]  data_idx;
  logic              data_vld;
  logic              cur_valid;
  drs_entry_t        cur;
  logic [15:0]       head;
  logic              status;
  logic [CNT_W-1:0]  best_idx;
  logic [31:0]       best_key;
  drs_entry_t        best_entry;

  drs_entry_t        mem [QUEUE_DEPTH];
  drs_entry_t        rd_data;
  logic [QIDX_W-1:0] rd_addr;
  logic              wr_en;
  logic [QIDX_W-1:0] wr_addr;
  drs_entry_t        wr_data;

  logic              req_accept;
  logic              rsp_take;
  logic              rsp_load;
  logic              issue_ok;
  logic              last_data;
  logic              take;
  logic [15:0]       seek_gap;
  logic [31:0]       cand_key;
  logic [CNT_W-1:0]  sel_idx;
  logic [CNT_W-1:0]  shift_dst;
  drs_entry_t        sel_entry;
  drs_entry_t        new_entry;

  assign req_accept = req_valid && !req_stall;
  assign rsp_take   = rsp_valid && !rsp_stall;
  assign rsp_load   = (state == ST_FIN) && (!rsp_valid || !rsp_stall);
  assign total_m1   = total - CNT_W'(1);
  assign issue_ok   = (ptr < total);
  assign last_data  = data_vld && (data_idx == total_m1);
  assign rd_addr    = ptr[QIDX_W-1:0];
  assign shift_dst  = data_idx - CNT_W'(1);

  assign new_entry.req_tag       = req.new_request_id;
  assign new_entry.proc_tag      = req.new_process_id;
  assign new_entry.block_address = req.new_block_address;
  assign new_entry.cylinder      = req.new_cylinder;
  assign new_entry.arrival_time  = req.new_arrival_time;

  assign seek_gap  = (head >= rd_data.cylinder) ? (head - rd_data.cylinder)
                                                : (rd_data.cylinder - head);
  assign cand_key  = (policy_mode == POLICY_SSTF) ? {16'd0, seek_gap} : rd_data.arrival_time;
  assign take      = (data_idx == '0) || (cand_key < best_key);
  assign sel_idx   = take ? data_idx : best_idx;
  assign sel_entry = take ? rd_data : best_entry;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_accept) begin
          if (req.opcode == OP_ARRIVE || total == '0) begin
            state_next = ST_FIN;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (last_data) begin
          state_next = (sel_idx == total_m1) ? ST_FIN : ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (last_data) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (rsp_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_stall = 1'b1;
    wr_en     = 1'b0;
    wr_addr   = total[QIDX_W-1:0];
    wr_data   = new_entry;
    unique case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        wr_en     = req_accept && (req.opcode == OP_ARRIVE) && cur_valid &&
                    (total < CNT_W'(QUEUE_DEPTH));
      end
      ST_SHIFT: begin
        wr_en   = data_vld;
        wr_addr = shift_dst[QIDX_W-1:0];
        wr_data = rd_data;
      end
      default: req_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      policy_mode <= POLICY_FCFS;
      total       <= '0;
      ptr         <= '0;
      data_vld    <= 1'b0;
      cur_valid   <= 1'b0;
      cur         <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (policy_we) begin
        policy_mode <= policy_data;
      end
      data_vld <= (state == ST_SCAN || state == ST_SHIFT) && issue_ok;
      data_idx <= ptr;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_take) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_accept) begin
            head   <= req.head_cylinder;
            status <= STATUS_OK;
            ptr    <= '0;
            if (req.opcode == OP_ARRIVE) begin
              if (!cur_valid) begin
                cur_valid <= 1'b1;
                cur       <= new_entry;
              end else if (total < CNT_W'(QUEUE_DEPTH)) begin
                total <= total + CNT_W'(1);
              end else begin
                status <= STATUS_DROPPED;
              end
            end else if (total == '0) begin
              cur_valid <= 1'b0;
              cur       <= '0;
            end
          end
        end
        ST_SCAN: begin
          if (data_vld) begin
            best_idx   <= sel_idx;
            best_key   <= take ? cand_key : best_key;
            best_entry <= sel_entry;
          end
          if (last_data) begin
            cur_valid <= 1'b1;
            cur       <= sel_entry;
            ptr       <= sel_idx + CNT_W'(1);
            if (sel_idx == total_m1) begin
              total <= total_m1;
            end
          end else if (issue_ok) begin
            ptr <= ptr + CNT_W'(1);
          end
        end
        ST_SHIFT: begin
          if (issue_ok) begin
            ptr <= ptr + CNT_W'(1);
          end
          if (last_data) begin
            total <= total_m1;
          end
        end
        ST_FIN: begin
          if (rsp_load) begin
            rsp.status                <= status;
            rsp.serving_valid         <= cur_valid;
            rsp.serving_request_id    <= cur_valid ? cur.req_tag : 16'd0;
            rsp.serving_process_id    <= cur_valid ? cur.proc_tag : 16'd0;
            rsp.serving_block_address <= cur_valid ? cur.block_address : 32'd0;
            rsp.serving_cylinder      <= cur_valid ? cur.cylinder : 16'd0;
            rsp.serving_arrival_time  <= cur_valid ? cur.arrival_time : 32'd0;
            rsp.pending_count         <= 5'(total);
          end
        end
        default: begin
          ptr <= '0;
        end
      endcase
    end
  end

  a_total_bounded: assert property (@(posedge clk) disable iff (rst)
    total <= CNT_W'(QUEUE_DEPTH))
    else $error("Queue count exceeds its depth.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_accept |=> req_stall)
    else $error("A second transaction was accepted before the first finished.");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.serving_valid) |->
      (rsp.serving_request_id == 16'd0 && rsp.serving_block_address == 32'd0 &&
       rsp.serving_arrival_time == 32'd0))
    else $error("Idle response carries a request.");

  a_drop_when_full: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == STATUS_DROPPED) |->
      (rsp.pending_count == 5'(QUEUE_DEPTH) && rsp.serving_valid))
    else $error("Arrival dropped while the queue had room.");

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// Disk request scheduler testbench
// Sends arrivals and completions through the request channel and predicts
// every response with a behavioral scheduler that keeps its own request in
// service, pending queue and policy. Each response transaction is compared
// field by field. Directed cases cover a completion while idle, a queue
// overflow with a dropped arrival, arrival time ties and seek distance ties.
// Random traffic then runs under both policies with a changing arrival mix.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import drs_pkg::*;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  drs_req_t req = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  drs_rsp_t rsp;
  logic     policy_we = 1'b0;
  logic     policy_data = 1'b0;

  bit         no_idle = 1'b0;
  int         errors = 0;
  drs_rsp_t   replies_due[$];
  drs_entry_t queued_reqs[$];
  drs_entry_t in_service = '0;
  logic       in_service_valid = 1'b0;
  logic       pick_policy = POLICY_FCFS;

  disk_request_scheduler u_top (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .policy_we   (policy_we),
    .policy_data (policy_data)
  );

  always #6 clk = ~clk;

  function automatic logic [15:0] seek_span(input logic [15:0] a, input logic [15:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic drs_rsp_t schedule_step(input drs_req_t c);
    drs_rsp_t   r;
    drs_entry_t e;
    int         pick;
    r = '0;
    r.status = STATUS_OK;
    if (c.opcode == OP_ARRIVE) begin
      e.req_tag       = c.new_request_id;
      e.proc_tag      = c.new_process_id;
      e.block_address = c.new_block_address;
      e.cylinder      = c.new_cylinder;
      e.arrival_time  = c.new_arrival_time;
      if (!in_service_valid) begin
        in_service_valid = 1'b1;
        in_service = e;
      end else if (queued_reqs.size() < QUEUE_DEPTH) begin
        queued_reqs.push_back(e);
      end else begin
        r.status = STATUS_DROPPED;
      end
    end else if (queued_reqs.size() == 0) begin
      in_service_valid = 1'b0;
      in_service = '0;
    end else begin
      pick = 0;
      for (int i = 1; i < queued_reqs.size(); i++) begin
        if (pick_policy == POLICY_FCFS) begin
          if (queued_reqs[i].arrival_time < queued_reqs[pick].arrival_time) pick = i;
        end else if (seek_span(c.head_cylinder, queued_reqs[i].cylinder) <
                     seek_span(c.head_cylinder, queued_reqs[pick].cylinder)) begin
          pick = i;
        end
      end
      in_service_valid = 1'b1;
      in_service = queued_reqs[pick];
      queued_reqs.delete(pick);
    end
    r.serving_valid = in_service_valid;
    if (in_service_valid) begin
      r.serving_request_id    = in_service.req_tag;
      r.serving_process_id    = in_service.proc_tag;
      r.serving_block_address = in_service.block_address;
      r.serving_cylinder      = in_service.cylinder;
      r.serving_arrival_time  = in_service.arrival_time;
    end
    r.pending_count = 5'(queued_reqs.size());
    return r;
  endfunction

  function automatic drs_req_t arrival(input logic [15:0] rid, input logic [15:0] pid,
                                       input logic [31:0] addr, input logic [15:0] cyl,
                                       input logic [31:0] atime);
    drs_req_t c;
    c = '0;
    c.opcode            = OP_ARRIVE;
    c.new_request_id    = rid;
    c.new_process_id    = pid;
    c.new_block_address = addr;
    c.new_cylinder      = cyl;
    c.new_arrival_time  = atime;
    return c;
  endfunction

  function automatic drs_req_t completion(input logic [15:0] head);
    drs_req_t c;
    c = '0;
    c.opcode        = OP_COMPLETE;
    c.head_cylinder = head;
    return c;
  endfunction

  function automatic drs_req_t random_cmd(input int arrive_pct);
    drs_req_t c;
    c.opcode            = ($urandom_range(99) < arrive_pct) ? OP_ARRIVE : OP_COMPLETE;
    c.new_request_id    = 16'($urandom);
    c.new_process_id    = 16'($urandom);
    c.new_block_address = $urandom;
    case ($urandom_range(2))
      0: c.new_cylinder = 16'($urandom_range(0, 4)) * 16'd1000;
      1: c.new_cylinder = 16'hFFFF - 16'($urandom_range(0, 3));
      default: c.new_cylinder = 16'($urandom);
    endcase
    case ($urandom_range(2))
      0: c.new_arrival_time = $urandom_range(0, 5);
      1: c.new_arrival_time = 32'hFFFF_FFFF - $urandom_range(0, 5);
      default: c.new_arrival_time = $urandom;
    endcase
    if ($urandom_range(1) == 0) begin
      c.head_cylinder = 16'($urandom_range(0, 4)) * 16'd1000 + 16'd500;
    end else begin
      c.head_cylinder = 16'($urandom);
    end
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 'h%0h expected 'h%0h", name, got, want));
    end
  endtask

  // The transaction is accepted at the edge where valid is high and stall is low.
  task automatic send_cmd(input drs_req_t c);
    if (!no_idle && $urandom_range(99) < 11) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= c;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    replies_due.push_back(schedule_step(c));
  endtask

  task automatic wait_drained;
    req_valid <= 1'b0;
    @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_policy(input logic mode);
    @(posedge clk);
    policy_we <= 1'b1;
    policy_data <= mode;
    @(posedge clk);
    policy_we <= 1'b0;
    pick_policy = mode;
  endtask

  always @(posedge clk) begin
    drs_rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (replies_due.size() == 0) begin
        report_mismatch("response transaction with none expected");
      end else begin
        want = replies_due.pop_front();
        check_field("status", 32'(rsp.status), 32'(want.status));
        check_field("serving_valid", 32'(rsp.serving_valid), 32'(want.serving_valid));
        check_field("serving_request_id", 32'(rsp.serving_request_id),
                    32'(want.serving_request_id));
        check_field("serving_process_id", 32'(rsp.serving_process_id),
                    32'(want.serving_process_id));
        check_field("serving_block_address", rsp.serving_block_address,
                    want.serving_block_address);
        check_field("serving_cylinder", 32'(rsp.serving_cylinder),
                    32'(want.serving_cylinder));
        check_field("serving_arrival_time", rsp.serving_arrival_time,
                    want.serving_arrival_time);
        check_field("pending_count", 32'(rsp.pending_count), 32'(want.pending_count));
      end
    end
    rsp_stall <= !no_idle && ($urandom_range(99) < 11);
  end

  task automatic test_idle_completion;
    send_cmd(completion(16'hFFFF));
    wait_drained;
  endtask

  // Two entries share the earliest arrival time, so the lower position must win.
  task automatic test_overflow_fcfs;
    set_policy(POLICY_FCFS);
    send_cmd(arrival('0, '0, '0, '0, '0));
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      send_cmd(arrival(16'h0100 + 16'(k), 16'hFF00 - 16'(k), $urandom, 16'(k * 4368),
                       (k == 5 || k == 9) ? 32'd7 : 32'hFFFF_FFFF - 32'(k)));
    end
    send_cmd(arrival('1, '1, '1, '1, '1));
    send_cmd(completion('0));
    send_cmd(completion('0));
    wait_drained;
  endtask

  // The last head sits exactly between two queued cylinders.
  task automatic test_sstf_pick;
    set_policy(POLICY_SSTF);
    send_cmd(completion(16'd0));
    send_cmd(completion(16'hFFFF));
    send_cmd(completion(16'd32760));
    wait_drained;
  endtask

  task automatic test_random_traffic(input logic mode, input int count, input bit steady);
    int arrive_pct;
    arrive_pct = 50;
    set_policy(mode);
    no_idle = steady;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(3))
          0: arrive_pct = 30;
          1: arrive_pct = 55;
          2: arrive_pct = 70;
          default: arrive_pct = 90;
        endcase
      end
      send_cmd(random_cmd(arrive_pct));
      if ($urandom_range(199) == 0) wait_drained;
    end
    wait_drained;
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_idle_completion();
    test_overflow_fcfs();
    test_sstf_pick();
    test_random_traffic(POLICY_FCFS, 500, 1'b0);
    test_random_traffic(POLICY_SSTF, 500, 1'b0);
    test_random_traffic(POLICY_FCFS, 450, 1'b1);
    test_random_traffic(POLICY_SSTF, 500, 1'b0);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb failed");
    $finish;
  end

endmodule
